// ===== rtl/core/sepsum_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepsum_pkg
// Shared constants and types of the strip energy persistence sum: field
// widths, stream packing offsets, history row and pipeline item layouts.
// ----------------------------------------------------------------------------
package sepsum_pkg;

   // Geometry of the history
   localparam int WINDOW_DEPTH = 8;
   localparam int HIST_DEPTH   = WINDOW_DEPTH - 1;
   localparam int HALF_DEPTH   = WINDOW_DEPTH / 2;
   localparam int STRIP_BITS   = 6;
   localparam int SLOT_BITS    = 1;
   localparam int ENERGY_BITS  = 13;
   localparam int LINE_BITS    = STRIP_BITS + SLOT_BITS;
   localparam int LINE_COUNT   = 1 << LINE_BITS;
   localparam int WIN_BITS     = 3;

   // Stream packing, lowest field first
   localparam int STRIP_LSB    = 0;
   localparam int SLOT_LSB     = STRIP_LSB + STRIP_BITS;
   localparam int EA_LSB       = SLOT_LSB + SLOT_BITS;
   localparam int EB_LSB       = EA_LSB + ENERGY_BITS;
   localparam int FIELD_BITS   = EB_LSB + ENERGY_BITS;
   localparam int DATA_BITS    = ((FIELD_BITS + 7) / 8) * 8;
   localparam int PAD_BITS     = DATA_BITS - FIELD_BITS;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_WINDOW_FRAMES = 1'b0;

   typedef logic [ENERGY_BITS-1:0] energy_type;
   typedef logic [STRIP_BITS-1:0]  strip_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [LINE_BITS-1:0]   line_type;
   typedef logic [WIN_BITS-1:0]    window_type;

   // One stored row: the older entries of one delay line, newest first
   typedef struct packed {
      energy_type [HIST_DEPTH-1:0] a;
      energy_type [HIST_DEPTH-1:0] b;
   } hist_row_type;

   // Full window of one item after the new sample is shifted in
   typedef struct packed {
      strip_type                     strip;
      slot_type                      slot;
      energy_type [WINDOW_DEPTH-1:0] a;
      energy_type [WINDOW_DEPTH-1:0] b;
   } row_item_type;

endpackage

// ===== rtl/core/strip_energy_persistence_sum.sv =====
`timescale 1ns / 1ps
// A sample passes the history's shift and output stages, then the adder's
// half-sum and output stages. Throughput: one sample per cycle while results
// are taken; the history row memory has one read and one write port, and a
// row written the cycle before is forwarded. Reset clears the window register
// and all history row valid bits: delay lines read as zero, no clearing pass.
// ----------------------------------------------------------------------------
// strip_energy_persistence_sum
// Per-strip moving-window energy sum over the recent frames of each strip
// and read slot, on stream channels with a register port for the window.
// ----------------------------------------------------------------------------
module strip_energy_persistence_sum import sepsum_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Sample channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // strip_index[5:0], read_slot[6], energy_a[19:7], energy_b[32:20], zero pad
   input  logic [DATA_BITS-1:0]     req_tdata,
   // Result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_strip[5:0], out_slot[6], sum_a[19:7], sum_b[32:20], zero pad
   output logic [DATA_BITS-1:0]     rsp_tdata,
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   window_type   window_frames;
   row_item_type row_item;
   logic         row_valid;
   logic         row_ready;
   strip_type    out_strip;
   slot_type     out_slot;
   energy_type   sum_a;
   energy_type   sum_b;

   sepsum_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .window_frames (window_frames)
   );

   // Unpack the sample fields
   sepsum_hist u_hist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_strip  (req_tdata[STRIP_LSB +: STRIP_BITS]),
      .in_slot   (req_tdata[SLOT_LSB +: SLOT_BITS]),
      .in_ea     (req_tdata[EA_LSB +: ENERGY_BITS]),
      .in_eb     (req_tdata[EB_LSB +: ENERGY_BITS]),
      .out_valid (row_valid),
      .out_ready (row_ready),
      .out_item  (row_item)
   );

   sepsum_adder u_adder (
      .clock         (clock),
      .reset         (reset),
      .window_frames (window_frames),
      .in_valid      (row_valid),
      .in_ready      (row_ready),
      .in_item       (row_item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_strip     (out_strip),
      .out_slot      (out_slot),
      .sum_a         (sum_a),
      .sum_b         (sum_b)
   );

   // Pack the result fields, lowest first, zero padded
   assign rsp_tdata = {{PAD_BITS{1'b0}}, sum_b, sum_a, out_slot, out_strip};

endmodule

// ===== rtl/core/sepsum_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepsum_csr
// Register port: holds the window length register and serves reads.
// ----------------------------------------------------------------------------
module sepsum_csr import sepsum_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output window_type               window_frames
);

   window_type window_ff;
   logic       wr_en;
   logic       sel_window;

   assign csr_pready = 1'b1;
   assign sel_window = (csr_paddr[CSR_ADDR_BITS-1 -: 1] == REG_WINDOW_FRAMES);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Take the write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en && sel_window) begin
         window_ff <= csr_pwdata[WIN_BITS-1:0];
      end
   end

   // Return the register, zero elsewhere
   always_comb begin
      csr_prdata = '0;
      if (sel_window) begin
         csr_prdata = CSR_DATA_BITS'(window_ff);
      end
   end

   assign window_frames = window_ff;

endmodule

// ===== rtl/core/sepsum_hist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepsum_hist
// History store and shift stage: reads the row of the sample's delay line,
// shifts the new sample in, writes the row back and hands on the window.
// ----------------------------------------------------------------------------
module sepsum_hist import sepsum_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  strip_type    in_strip,
   input  slot_type     in_slot,
   input  energy_type   in_ea,
   input  energy_type   in_eb,
   output logic         out_valid,
   input  logic         out_ready,
   output row_item_type out_item
);

   // Row memory and per-row valid bits (an unwritten row reads as zero)
   hist_row_type           mem_ff [LINE_COUNT];
   logic [LINE_COUNT-1:0]  line_vld_ff;

   // Shift stage
   logic         s1_vld_ff;
   strip_type    s1_strip_ff;
   slot_type     s1_slot_ff;
   energy_type   s1_ea_ff;
   energy_type   s1_eb_ff;
   hist_row_type rd_row_ff;
   logic         rd_vld_ff;

   // Most recent write, for a row read in the same cycle it was written
   logic         last_vld_ff;
   line_type     last_line_ff;
   hist_row_type last_row_ff;

   // Output stage
   logic         out_vld_ff;
   row_item_type out_item_ff;

   line_type     in_line;
   line_type     s1_line;
   logic         accept;
   logic         s1_adv;
   logic         fwd_hit;
   hist_row_type old_row;
   hist_row_type new_row_in;
   row_item_type item_in;

   assign in_line  = {in_strip, in_slot};
   assign s1_line  = {s1_strip_ff, s1_slot_ff};
   assign s1_adv   = s1_vld_ff && (!out_vld_ff || out_ready);
   assign in_ready = !s1_vld_ff || s1_adv;
   assign accept   = in_valid && in_ready;
   assign fwd_hit  = last_vld_ff && (last_line_ff == s1_line);

   // Pick the current row and shift the new sample in
   always_comb begin
      if (fwd_hit) begin
         old_row = last_row_ff;
      end else if (rd_vld_ff) begin
         old_row = rd_row_ff;
      end else begin
         old_row = '0;
      end
      new_row_in.a[0] = s1_ea_ff;
      new_row_in.b[0] = s1_eb_ff;
      for (int k = 1; k < HIST_DEPTH; k++) begin
         new_row_in.a[k] = old_row.a[k-1];
         new_row_in.b[k] = old_row.b[k-1];
      end
      item_in.strip = s1_strip_ff;
      item_in.slot  = s1_slot_ff;
      item_in.a[0]  = s1_ea_ff;
      item_in.b[0]  = s1_eb_ff;
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
         item_in.a[k] = old_row.a[k-1];
         item_in.b[k] = old_row.b[k-1];
      end
   end

   // Read the row on the transfer in
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff   <= mem_ff[in_line];
         rd_vld_ff   <= line_vld_ff[in_line];
         s1_strip_ff <= in_strip;
         s1_slot_ff  <= in_slot;
         s1_ea_ff    <= in_ea;
         s1_eb_ff    <= in_eb;
      end
   end

   // Write the shifted row back as the item leaves the shift stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem_ff[s1_line] <= new_row_in;
         last_line_ff    <= s1_line;
         last_row_ff     <= new_row_in;
      end
   end

   // Control: stage valids, row valid bits, last-write flag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         last_vld_ff <= 1'b0;
         line_vld_ff <= '0;
      end else begin
         if (in_ready) begin
            s1_vld_ff <= in_valid;
         end
         if (!out_vld_ff || out_ready) begin
            out_vld_ff <= s1_vld_ff;
         end
         if (s1_adv) begin
            last_vld_ff          <= 1'b1;
            line_vld_ff[s1_line] <= 1'b1;
         end
      end
   end

   // Hold the window for the adder
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_item_ff <= item_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_item  = out_item_ff;

`ifndef SYNTHESIS
   // A stalled item keeps its line, so no write can slip past its read
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_adv |=> s1_vld_ff && $stable(s1_line))
      else $error("shift stage lost its line while stalled");

   // The last-write record follows every write back
   a_last_wr: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> last_vld_ff && (last_line_ff == $past(s1_line)))
      else $error("last write record does not match written line");

   // A written row is marked valid
   a_row_vld: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> line_vld_ff[$past(s1_line)])
      else $error("written row not marked valid");

   // The output stage fills whenever the shift stage advances
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_vld_ff)
      else $error("advanced item missing from output stage");
`endif

endmodule

// ===== rtl/core/sepsum_adder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepsum_adder
// Window adder: masks entries beyond the window, adds each half of the
// window in one stage and the two halves in the next, into the output.
// ----------------------------------------------------------------------------
module sepsum_adder import sepsum_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  window_type   window_frames,
   input  logic         in_valid,
   output logic         in_ready,
   input  row_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output strip_type    out_strip,
   output slot_type     out_slot,
   output energy_type   sum_a,
   output energy_type   sum_b
);

   // Half-sum stage
   logic       p_vld_ff;
   strip_type  p_strip_ff;
   slot_type   p_slot_ff;
   energy_type lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff;

   // Output stage
   logic       o_vld_ff;
   strip_type  o_strip_ff;
   slot_type   o_slot_ff;
   energy_type o_sum_a_ff, o_sum_b_ff;

   energy_type lo_a_in, hi_a_in, lo_b_in, hi_b_in;
   logic       o_open;

   assign o_open   = !o_vld_ff || out_ready;
   assign in_ready = !p_vld_ff || o_open;

   // Sum each half of the window, dropping entries past its length
   always_comb begin
      lo_a_in = '0;
      hi_a_in = '0;
      lo_b_in = '0;
      hi_b_in = '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         if (k <= int'(window_frames)) begin
            if (k < HALF_DEPTH) begin
               lo_a_in = lo_a_in + in_item.a[k];
               lo_b_in = lo_b_in + in_item.b[k];
            end else begin
               hi_a_in = hi_a_in + in_item.a[k];
               hi_b_in = hi_b_in + in_item.b[k];
            end
         end
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            p_vld_ff <= in_valid;
         end
         if (o_open) begin
            o_vld_ff <= p_vld_ff;
         end
      end
   end

   // Half sums
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         p_strip_ff <= in_item.strip;
         p_slot_ff  <= in_item.slot;
         lo_a_ff    <= lo_a_in;
         hi_a_ff    <= hi_a_in;
         lo_b_ff    <= lo_b_in;
         hi_b_ff    <= hi_b_in;
      end
   end

   // Final sums, wrapping at the energy width
   always_ff @(posedge clock) begin
      if (p_vld_ff && o_open) begin
         o_strip_ff <= p_strip_ff;
         o_slot_ff  <= p_slot_ff;
         o_sum_a_ff <= lo_a_ff + hi_a_ff;
         o_sum_b_ff <= lo_b_ff + hi_b_ff;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_strip = o_strip_ff;
   assign out_slot  = o_slot_ff;
   assign sum_a     = o_sum_a_ff;
   assign sum_b     = o_sum_b_ff;

`ifndef SYNTHESIS
   // A half sum that moves on lands in the output stage
   a_p_to_o: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff && o_open |=> o_vld_ff)
      else $error("half sum lost on the way to the output");

   // A held half sum keeps its strip while the output is blocked
   a_p_hold: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff && !o_open |=> p_vld_ff && $stable(p_strip_ff))
      else $error("half sum stage changed while stalled");

   // A result waiting on the receiver stays put
   a_o_hold: assert property (@(posedge clock) disable iff (reset)
      o_vld_ff && !out_ready |=> o_vld_ff && $stable(o_sum_a_ff) && $stable(o_sum_b_ff))
      else $error("result changed while stalled");
`endif

endmodule
